// ----- rtl/core/ibfe_pkg.sv -----
// shared types, constants and character classification for the ita2 frame encoder
package ibfe_pkg;

	localparam int CHAR_W      = 8;
	localparam int CODE_W      = 5;
	localparam int HALF_W      = 2;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CODE_W-1:0] CODE_FIGS = 5'h1B;
	localparam logic [CODE_W-1:0] CODE_LTRS = 5'h1F;
	localparam logic [CODE_W-1:0] CODE_NULL = 5'h00;
	localparam logic [CODE_W-1:0] CODE_CR   = 5'h02;
	localparam logic [CODE_W-1:0] CODE_LF   = 5'h08;
	localparam logic [CODE_W-1:0] CODE_SP   = 5'h04;

	localparam logic [HALF_W-1:0] HALF_DATA = 2'd2;
	localparam logic [HALF_W-1:0] HALF_STOP = 2'd3;

	localparam logic [CODE_W-1:0] LETTER_CODE [26] = '{
		5'h18, 5'h13, 5'h0E, 5'h12, 5'h10, 5'h16, 5'h0B, 5'h05, 5'h0C, 5'h1A,
		5'h1E, 5'h09, 5'h07, 5'h06, 5'h03, 5'h0D, 5'h1D, 5'h0A, 5'h14, 5'h01,
		5'h1C, 5'h0F, 5'h19, 5'h17, 5'h15, 5'h11
	};

	localparam logic [CODE_W-1:0] DIGIT_CODE [10] = '{
		5'h0D, 5'h1D, 5'h19, 5'h10, 5'h0A, 5'h01, 5'h15, 5'h1C, 5'h0C, 5'h03
	};

	typedef struct packed {
		logic              figs;
		logic [CODE_W-1:0] code;
	} entry_t;

	function automatic entry_t classify(input logic [CHAR_W-1:0] c);
		entry_t            e;
		logic [CHAR_W-1:0] off;
		e.figs = 1'b0;
		e.code = CODE_NULL;
		off    = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			off    = c - 8'h41;
			e.code = LETTER_CODE[off[4:0]];
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			off    = c - 8'h61;
			e.code = LETTER_CODE[off[4:0]];
		end else if (c >= 8'h30 && c <= 8'h39) begin
			off    = c - 8'h30;
			e.figs = 1'b1;
			e.code = DIGIT_CODE[off[3:0]];
		end else begin
			case (c)
				8'h0D: e.code = CODE_CR;
				8'h0A: e.code = CODE_LF;
				8'h20: e.code = CODE_SP;
				8'h5B: e.code = CODE_FIGS;
				8'h5D: e.code = CODE_LTRS;
				8'h2D: begin e.figs = 1'b1; e.code = 5'h18; end
				8'h24: begin e.figs = 1'b1; e.code = 5'h12; end
				8'h21: begin e.figs = 1'b1; e.code = 5'h16; end
				8'h26: begin e.figs = 1'b1; e.code = 5'h0B; end
				8'h23: begin e.figs = 1'b1; e.code = 5'h05; end
				8'h27: begin e.figs = 1'b1; e.code = 5'h1A; end
				8'h28: begin e.figs = 1'b1; e.code = 5'h1E; end
				8'h29: begin e.figs = 1'b1; e.code = 5'h09; end
				8'h22: begin e.figs = 1'b1; e.code = 5'h11; end
				8'h2F: begin e.figs = 1'b1; e.code = 5'h17; end
				8'h3A: begin e.figs = 1'b1; e.code = 5'h0E; end
				8'h3B: begin e.figs = 1'b1; e.code = 5'h0F; end
				8'h3F: begin e.figs = 1'b1; e.code = 5'h13; end
				8'h2C: begin e.figs = 1'b1; e.code = 5'h06; end
				8'h2E: begin e.figs = 1'b1; e.code = 5'h07; end
				default: e.code = CODE_NULL;
			endcase
		end
		return e;
	endfunction

endpackage

// ----- rtl/core/ibfe_front.sv -----
// front stage: takes a character request, classifies it and hands it to the queue
module ibfe_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          char_valid,
	output logic                          char_stall,
	input  logic [ibfe_pkg::CHAR_W-1:0]   character,
	output logic                          push,
	output ibfe_pkg::entry_t              push_entry,
	input  logic                          q_full
);

	logic             valid_s1;
	ibfe_pkg::entry_t entry_s1;
	logic             take;

	assign char_stall = valid_s1 && q_full;
	assign take       = char_valid && !char_stall;
	assign push       = valid_s1 && !q_full;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1 <= ibfe_pkg::classify(character);
		end
	end

endmodule

// ----- rtl/core/ibfe_queue.sv -----
// short fifo of classified characters between front and serializer
module ibfe_queue #(
	parameter int DEPTH = ibfe_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ibfe_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output ibfe_pkg::entry_t q_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ibfe_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_entry = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ----- rtl/core/ibfe_back.sv -----
// serializer: classified character to line symbols, one per cycle unless stalled
module ibfe_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  ibfe_pkg::entry_t              q_entry,
	output logic                          pop,
	output logic                          sym_valid,
	input  logic                          sym_stall,
	output logic                          level,
	output logic [ibfe_pkg::HALF_W-1:0]   half_bits,
	output logic                          last
);

	localparam logic [1:0] FRAME_SHIFT = 2'd0;
	localparam logic [1:0] FRAME_CHAR  = 2'd1;
	localparam logic [1:0] FRAME_EXTRA = 2'd3;
	localparam logic [2:0] POS_START   = 3'd0;
	localparam logic [2:0] POS_STOP    = 3'd6;
	localparam logic [2:0] POS_TOP     = 3'd5;

	logic                          busy_q;
	ibfe_pkg::entry_t              cur_q;
	logic [1:0]                    frame_q;
	logic [2:0]                    pos_q;
	logic                          out_valid_q;
	logic                          level_q;
	logic [ibfe_pkg::HALF_W-1:0]   half_q;
	logic                          last_q;

	logic                          load_ok;
	logic                          emit;
	logic [ibfe_pkg::CODE_W-1:0]   frame_code;
	logic [2:0]                    bit_idx;
	logic                          sym_level;
	logic [ibfe_pkg::HALF_W-1:0]   sym_half;
	logic                          sym_last;

	assign load_ok = !out_valid_q || !sym_stall;
	assign emit    = busy_q && load_ok;
	assign pop     = q_valid && (!busy_q || (emit && sym_last));
	assign bit_idx = POS_TOP - pos_q;

	always_comb begin
		if (!cur_q.figs || frame_q == FRAME_CHAR) begin
			frame_code = cur_q.code;
		end else if (frame_q == FRAME_SHIFT) begin
			frame_code = ibfe_pkg::CODE_FIGS;
		end else begin
			frame_code = ibfe_pkg::CODE_LTRS;
		end
		if (cur_q.figs && frame_q == FRAME_EXTRA) begin
			sym_level = 1'b1;
			sym_half  = ibfe_pkg::HALF_STOP;
			sym_last  = 1'b1;
		end else if (pos_q == POS_START) begin
			sym_level = 1'b0;
			sym_half  = ibfe_pkg::HALF_DATA;
			sym_last  = 1'b0;
		end else if (pos_q == POS_STOP) begin
			sym_level = 1'b1;
			sym_half  = ibfe_pkg::HALF_STOP;
			sym_last  = !cur_q.figs;
		end else begin
			sym_level = frame_code[bit_idx];
			sym_half  = ibfe_pkg::HALF_DATA;
			sym_last  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			frame_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q  <= 1'b1;
				frame_q <= FRAME_SHIFT;
				pos_q   <= POS_START;
			end else if (emit) begin
				if (sym_last) begin
					busy_q <= 1'b0;
				end else if (pos_q == POS_STOP) begin
					pos_q   <= POS_START;
					frame_q <= frame_q + 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!sym_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_entry;
		end
		if (emit) begin
			level_q <= sym_level;
			half_q  <= sym_half;
			last_q  <= sym_last;
		end
	end

	assign sym_valid = out_valid_q;
	assign level     = level_q;
	assign half_bits = half_q;
	assign last      = last_q;

endmodule

// ----- rtl/core/ita2_baudot_frame_encoder.sv -----
// top level of the ita2 frame encoder: front classifier, queue and symbol serializer
//
// channel  direction  handshake             payload
// char     in         char_valid/char_stall character[7:0]
// sym      out        sym_valid/sym_stall   level, half_bits[1:0], last
//
// one symbol leaves per cycle unless the sink stalls; the serializer sets the rate:
// frames are start, five data, stop; figure characters add figs and ltrs frames and a stop.
// a queued next character's first symbol follows its predecessor's last one directly.
// a request crosses the front register, the queue and the serializer to its first symbol.
// reset clears control only; a stalled symbol holds while the front keeps filling the queue.
module ita2_baudot_frame_encoder #(
	parameter int QUEUE_DEPTH = ibfe_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          char_valid,
	output logic                          char_stall,
	input  logic [ibfe_pkg::CHAR_W-1:0]   character,
	output logic                          sym_valid,
	input  logic                          sym_stall,
	output logic                          level,
	output logic [ibfe_pkg::HALF_W-1:0]   half_bits,
	output logic                          last
);

	logic             push;
	ibfe_pkg::entry_t push_entry;
	logic             q_full;
	logic             pop;
	logic             q_valid;
	ibfe_pkg::entry_t q_entry;

	ibfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.character  (character),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	ibfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.q_entry    (q_entry)
	);

	ibfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.pop       (pop),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.level     (level),
		.half_bits (half_bits),
		.last      (last)
	);

endmodule

// ----- sim/ita2_baudot_frame_encoder_test.sv -----
// ita2 frame encoder testbench: directed and random characters vs a symbol scoreboard
`timescale 1ns / 1ps

module ita2_baudot_frame_encoder_test;

	localparam int LONG_HOLD   = 400;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 30;

	typedef struct packed {
		logic                        level;
		logic [ibfe_pkg::HALF_W-1:0] half_bits;
		logic                        last;
	} symbol_t;

	typedef enum {PACE_NONE, PACE_RANDOM, PACE_HOLD} pace_t;

	class symbol_scoreboard;
		symbol_t expected_symbols[$];
		int      errors;

		function new();
			errors = 0;
		endfunction

		// returns 1 when the character travels inside a figs/ltrs wrap
		function logic ita2_code(input logic [ibfe_pkg::CHAR_W-1:0] c,
			output logic [ibfe_pkg::CODE_W-1:0] code);
			logic [26*ibfe_pkg::CODE_W-1:0] letters;
			logic [10*ibfe_pkg::CODE_W-1:0] digits;
			logic [ibfe_pkg::CHAR_W-1:0]    idx;
			letters = {5'h18, 5'h13, 5'h0E, 5'h12, 5'h10, 5'h16, 5'h0B, 5'h05, 5'h0C,
				5'h1A, 5'h1E, 5'h09, 5'h07, 5'h06, 5'h03, 5'h0D, 5'h1D, 5'h0A, 5'h14,
				5'h01, 5'h1C, 5'h0F, 5'h19, 5'h17, 5'h15, 5'h11};
			digits = {5'h0D, 5'h1D, 5'h19, 5'h10, 5'h0A, 5'h01, 5'h15, 5'h1C, 5'h0C, 5'h03};
			ita2_code = 1'b0;
			code      = ibfe_pkg::CODE_NULL;
			if (c >= "A" && c <= "Z") begin
				idx  = c - "A";
				code = letters[(25 - idx) * ibfe_pkg::CODE_W +: ibfe_pkg::CODE_W];
			end else if (c >= "a" && c <= "z") begin
				idx  = c - "a";
				code = letters[(25 - idx) * ibfe_pkg::CODE_W +: ibfe_pkg::CODE_W];
			end else if (c >= "0" && c <= "9") begin
				idx       = c - "0";
				code      = digits[(9 - idx) * ibfe_pkg::CODE_W +: ibfe_pkg::CODE_W];
				ita2_code = 1'b1;
			end else begin
				ita2_code = 1'b1;
				case (c)
					8'h0D: begin code = ibfe_pkg::CODE_CR; ita2_code = 1'b0; end
					8'h0A: begin code = ibfe_pkg::CODE_LF; ita2_code = 1'b0; end
					" ": begin code = ibfe_pkg::CODE_SP; ita2_code = 1'b0; end
					"[": begin code = ibfe_pkg::CODE_FIGS; ita2_code = 1'b0; end
					"]": begin code = ibfe_pkg::CODE_LTRS; ita2_code = 1'b0; end
					"-": code = 5'h18;
					"$": code = 5'h12;
					"!": code = 5'h16;
					"&": code = 5'h0B;
					"#": code = 5'h05;
					"'": code = 5'h1A;
					"(": code = 5'h1E;
					")": code = 5'h09;
					"\"": code = 5'h11;
					"/": code = 5'h17;
					":": code = 5'h0E;
					";": code = 5'h0F;
					"?": code = 5'h13;
					",": code = 5'h06;
					".": code = 5'h07;
					default: begin code = ibfe_pkg::CODE_NULL; ita2_code = 1'b0; end
				endcase
			end
		endfunction

		function void push_stop();
			symbol_t s;
			s.level     = 1'b1;
			s.half_bits = ibfe_pkg::HALF_STOP;
			s.last      = 1'b0;
			expected_symbols.push_back(s);
		endfunction

		function void push_frame(input logic [ibfe_pkg::CODE_W-1:0] code);
			symbol_t s;
			int      b;
			s.level     = 1'b0;
			s.half_bits = ibfe_pkg::HALF_DATA;
			s.last      = 1'b0;
			expected_symbols.push_back(s);
			for (b = ibfe_pkg::CODE_W - 1; b >= 0; b--) begin
				s.level = code[b];
				expected_symbols.push_back(s);
			end
			push_stop();
		endfunction

		function void note_character(input logic [ibfe_pkg::CHAR_W-1:0] c);
			logic [ibfe_pkg::CODE_W-1:0] code;
			symbol_t                     tail;
			if (ita2_code(c, code)) begin
				push_frame(ibfe_pkg::CODE_FIGS);
				push_frame(code);
				push_frame(ibfe_pkg::CODE_LTRS);
				push_stop();
			end else begin
				push_frame(code);
			end
			tail      = expected_symbols.pop_back();
			tail.last = 1'b1;
			expected_symbols.push_back(tail);
		endfunction

		function void flag(input string what, input int want, input int got);
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		endfunction

		function void check_symbol(input logic level,
			input logic [ibfe_pkg::HALF_W-1:0] half_bits, input logic last);
			symbol_t want;
			if (expected_symbols.size() == 0) begin
				flag("unexpected symbol, pending count", 0, 1);
				return;
			end
			want = expected_symbols.pop_front();
			if (want.level !== level)
				flag("level", int'(want.level), int'(level));
			if (want.half_bits !== half_bits)
				flag("half_bits", int'(want.half_bits), int'(half_bits));
			if (want.last !== last)
				flag("last", int'(want.last), int'(last));
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        char_valid;
	logic                        char_stall;
	logic [ibfe_pkg::CHAR_W-1:0] character;
	logic                        sym_valid;
	logic                        sym_stall;
	logic                        level;
	logic [ibfe_pkg::HALF_W-1:0] half_bits;
	logic                        last;

	symbol_scoreboard sb;
	pace_t            tx_pace;
	pace_t            rx_pace;
	int               quiet_cycles;

	logic [ibfe_pkg::CHAR_W-1:0] directed_chars [20] = '{
		8'h00, 8'hFF, 8'h80, 8'h7F, "A", "Z", "a", "z", "0", "9",
		8'h0D, 8'h0A, " ", "[", "]", "-", "?", ".", "\"", "@"
	};

	ita2_baudot_frame_encoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.character  (character),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.level      (level),
		.half_bits  (half_bits),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int draw_wait(input pace_t pace);
		if (pace == PACE_RANDOM)
			return $urandom_range(0, 19);
		return 0;
	endfunction

	function automatic logic [ibfe_pkg::CHAR_W-1:0] pick_character();
		string figure_marks;
		int    r;
		int    s;
		figure_marks = "-$!&#'()\"/:;?,.";
		r = $urandom_range(0, 9);
		if (r <= 3) begin
			s = $urandom_range(0, 56);
			if (s < 26)
				return ibfe_pkg::CHAR_W'(8'h41 + s);
			if (s < 52)
				return ibfe_pkg::CHAR_W'(8'h61 + s - 26);
			case (s)
				52: return 8'h0D;
				53: return 8'h0A;
				54: return " ";
				55: return "[";
				default: return "]";
			endcase
		end
		if (r <= 6) begin
			s = $urandom_range(0, 24);
			if (s < 10)
				return ibfe_pkg::CHAR_W'(8'h30 + s);
			return figure_marks[s - 10];
		end
		return ibfe_pkg::CHAR_W'($urandom_range(0, 255));
	endfunction

	task automatic send_character(input logic [ibfe_pkg::CHAR_W-1:0] c);
		int gap;
		gap = draw_wait(tx_pace);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		character  <= c;
		do @(posedge clk); while (!(char_valid && !char_stall));
	endtask

	task automatic wait_all_symbols();
		char_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_symbols.size() > 0);
	endtask

	// sink side pacing
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (rx_pace == PACE_HOLD) begin
				sym_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rx_pace = PACE_RANDOM;
			end else begin
				n = draw_wait(rx_pace);
				if (n > 0) begin
					sym_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			sym_stall <= 1'b0;
			do @(posedge clk); while (!(sym_valid && !sym_stall));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall)
				sb.note_character(character);
			if (sym_valid && !sym_stall)
				sb.check_symbol(level, half_bits, last);
		end
	end

	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (sym_valid && !sym_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("ita2_baudot_frame_encoder: mismatch");
			$finish;
		end
	end

	initial begin
		sb           = new();
		quiet_cycles = 0;
		arst_n       = 1'b0;
		char_valid   = 1'b0;
		character    = '0;
		sym_stall    = 1'b0;
		tx_pace      = PACE_NONE;
		rx_pace      = PACE_NONE;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_chars[i])
			send_character(directed_chars[i]);

		tx_pace = PACE_RANDOM;
		rx_pace = PACE_RANDOM;
		repeat (100) send_character(pick_character());

		tx_pace = PACE_NONE;
		rx_pace = PACE_NONE;
		repeat (60) send_character(pick_character());

		// sink holds off while requests keep coming
		rx_pace = PACE_HOLD;
		repeat (40) send_character(pick_character());

		wait_all_symbols();
		tx_pace = PACE_RANDOM;
		rx_pace = PACE_NONE;
		repeat (50) send_character(pick_character());

		tx_pace = PACE_NONE;
		rx_pace = PACE_RANDOM;
		repeat (40) send_character(pick_character());

		wait_all_symbols();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.expected_symbols.size() == 0)
			$display("ita2_baudot_frame_encoder: match");
		else
			$display("ita2_baudot_frame_encoder: mismatch");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/ibfe_pkg.sv
rtl/core/ibfe_front.sv
rtl/core/ibfe_queue.sv
rtl/core/ibfe_back.sv
rtl/core/ita2_baudot_frame_encoder.sv
sim/ita2_baudot_frame_encoder_test.sv
